// ===== design/goertzel_tone_detector_q15_top_macros.svh =====
// ----------------------------------------------------------------------------
// Goertzel tone detector assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GOERTZEL_TONE_DETECTOR_Q15_TOP_MACROS_SVH
`define GOERTZEL_TONE_DETECTOR_Q15_TOP_MACROS_SVH

`ifndef SYNTH
// Checked at every rising edge outside reset.
`define GTD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("goertzel detector check failed");
// Checked at every rising edge, reset included.
`define GTD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("goertzel detector check failed");
`else
`define GTD_ASSERT(label, clk, rst, prop)
`define GTD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/gtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Goertzel tone detector package
// Shared widths, reset values, register indexes, sequencer types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 17;
  localparam int LEN_W      = 13;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int MUL_A_W    = 18;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 36;
  localparam int SUM_W      = 20;
  localparam int Q_SHIFT    = 15;

  localparam logic signed [COEF_W-1:0] COEF_RESET = COEF_W'(64973);
  localparam logic [LEN_W-1:0]         LEN_RESET  = LEN_W'(480);
  localparam logic [THR_W-1:0]         THR_RESET  = THR_W'(8191);

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = SAMPLE_W'(32767);
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = SAMPLE_W'(-32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFFICIENT  = 2'd0,
    REG_BLOCK_LENGTH = 2'd1,
    REG_THRESHOLD    = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_PW_CS,
    ST_PW_SQ1,
    ST_PW_SQ2,
    ST_PW_TS,
    ST_PW_FIN
  } state_t;

  typedef enum logic [1:0] {
    MUL_C_S1,
    MUL_S1_S1,
    MUL_S2_S2,
    MUL_T_S2
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     update;
    logic     take_t;
    logic     acc_load;
    logic     acc_add;
    logic     finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > ACC_W'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < ACC_W'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Goertzel tone detector controller
// Sequences the shared multiplier through the recurrence and power steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "goertzel_tone_detector_q15_top_macros.svh"

module gtd_ctrl
  import gtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_MUL;
      ST_MUL:    state_next = ST_UPD;
      ST_UPD:    state_next = status.is_last ? ST_PW_CS : ST_IDLE;
      ST_PW_CS:  state_next = ST_PW_SQ1;
      ST_PW_SQ1: state_next = ST_PW_SQ2;
      ST_PW_SQ2: state_next = ST_PW_TS;
      ST_PW_TS:  state_next = ST_PW_FIN;
      ST_PW_FIN: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_C_S1;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = accept;
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_C_S1;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
      end
      ST_PW_CS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_C_S1;
      end
      ST_PW_SQ1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S1_S1;
        cmd.take_t  = 1'b1;
      end
      ST_PW_SQ2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_S2_S2;
        cmd.acc_load = 1'b1;
      end
      ST_PW_TS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T_S2;
        cmd.acc_add = 1'b1;
      end
      ST_PW_FIN: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `GTD_ASSERT(a_accept_starts_mul, clk, rst, accept |=> (state == ST_MUL))
  `GTD_ASSERT(a_last_goes_power, clk, rst,
              (state == ST_UPD && status.is_last) |=> (state == ST_PW_CS))
  `GTD_ASSERT(a_mid_block_returns, clk, rst,
              (state == ST_UPD && !status.is_last) |=> (state == ST_IDLE))
  `GTD_ASSERT(a_finish_frees, clk, rst, cmd.finish |=> !sample_stall)

endmodule

// ===== design/gtd_datapath.sv =====
// ----------------------------------------------------------------------------
// Goertzel tone detector datapath
// Config registers, delay states, shared multiplier, accumulator, result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtd_datapath
  import gtd_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
)
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [SAMPLE_W-1:0]   power,
  output logic                         tone_detected,
  input  ctl_cmd_t                     cmd,
  output dp_status_t                   status
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int LW    = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

  logic signed [COEF_W-1:0]   coef;
  logic [LEN_W-1:0]           blen;
  logic [THR_W-1:0]           thr;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] s2;
  logic [CNT_W-1:0]           count;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [MUL_A_W-1:0]  t;
  logic signed [ACC_W-1:0]    acc;

  logic signed [SUM_W-1:0]    s_wide;
  logic signed [SAMPLE_W-1:0] s_sat;
  logic signed [ACC_W-1:0]    mag;
  logic signed [SAMPLE_W-1:0] power_next;
  logic [LW-1:0]              len_eff;
  logic [LW-1:0]              cnt_inc;

  // configuration writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
      blen <= LEN_RESET;
      thr  <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFFICIENT:  coef <= signed'(cfg_data[COEF_W-1:0]);
        REG_BLOCK_LENGTH: blen <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD:    thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block length: zero acts as one, clamp to MAX_BLOCK
  always_comb begin
    if (blen == '0) begin
      len_eff = LW'(1);
    end else if (LW'(blen) > LW'(MAX_BLOCK)) begin
      len_eff = LW'(MAX_BLOCK);
    end else begin
      len_eff = LW'(blen);
    end
    cnt_inc = LW'(count) + LW'(1);
  end

  assign status.is_last  = (cnt_inc >= len_eff);
  assign status.out_free = !result_valid || !result_stall;

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_C_S1: begin
        mul_a = MUL_A_W'(s1);
        mul_b = coef;
      end
      MUL_S1_S1: begin
        mul_a = MUL_A_W'(s1);
        mul_b = MUL_B_W'(s1);
      end
      MUL_S2_S2: begin
        mul_a = MUL_A_W'(s2);
        mul_b = MUL_B_W'(s2);
      end
      default: begin
        mul_a = t;
        mul_b = MUL_B_W'(s2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.capture) begin
      x <= sample;
    end
    if (cmd.take_t) begin
      t <= MUL_A_W'(prod >>> Q_SHIFT);
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // recurrence step: x + floor(c*s1 / 2^15) - s2, saturated
  always_comb begin
    s_wide = SUM_W'(x) + SUM_W'(prod >>> Q_SHIFT) - SUM_W'(s2);
    s_sat  = sat16(ACC_W'(s_wide));
  end

  // bin power: s1^2 + s2^2 - t*s2, then shift and saturate
  always_comb begin
    mag        = acc - ACC_W'(prod);
    power_next = sat16(mag >>> Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1    <= '0;
      s2    <= '0;
      count <= '0;
    end else if (cmd.finish) begin
      s1    <= '0;
      s2    <= '0;
      count <= '0;
    end else if (cmd.update) begin
      s2    <= s1;
      s1    <= s_sat;
      count <= count + CNT_W'(1);
    end
  end

  // result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      power         <= power_next;
      tone_detected <= ((SAMPLE_W + 1)'(power_next) > signed'({2'b00, thr}));
    end
  end

endmodule

// ===== design/goertzel_tone_detector_q15_top.sv =====
// ----------------------------------------------------------------------------
// Goertzel tone detector, Q15
// Single-bin Goertzel power detector with a controller and a datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on sample / sample_valid; the block raises sample_stall
//   while it works on a sample, so a beat is taken only while it is idle.
//   Each sample steps through accept, one pass of the shared 18x17
//   multiplier for coefficient * delay_one, and the state update.
//   The sample that completes a block adds four more passes of the
//   same multiplier (c*s1, s1^2, s2^2, t*s2) and a final subtract that loads
//   the result register; the result beat shows on power / tone_detected in
//   the cycle after that. The result register holds a finished beat while
//   result_stall is high; a new block's samples are still taken meanwhile,
//   and only a second result waits (in its final step) until the first has
//   been taken. Configuration goes through cfg_we / cfg_index / cfg_data,
//   one register a cycle; the user must write only while the block is idle
//   (not enforced by the block). A new value applies from the next sample.
//   Synchronous reset clears the delays, the count and the result beat and
//   restores coefficient 64973, block length 480 and threshold 8191.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "goertzel_tone_detector_q15_top_macros.svh"

module goertzel_tone_detector_q15_top
  import gtd_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] power,
  output logic                       tone_detected
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: owns the input handshake and steps the datapath
  gtd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: registers, delays, multiplier and the result beat
  gtd_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .power         (power),
    .tone_detected (tone_detected),
    .cmd           (cmd),
    .status        (status)
  );

  // a result beat is loaded only at the end of a block's power steps
  `GTD_ASSERT(a_result_from_power, clk, rst,
              $rose(result_valid) |-> $past(sample_stall))
  // a fresh result never lands on one still waiting to be taken
  `GTD_ASSERT(a_no_overwrite, clk, rst,
              (result_valid && result_stall) |=> (result_valid && $stable(power)))
  // reset leaves no result beat and an idle input
  `GTD_ASSERT_ALWAYS(a_reset_clear, clk,
                     $past(rst) |-> (!result_valid && !sample_stall))

endmodule
